// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL modules of the escape decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_IMPL(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("%m: same-cycle implication failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("%m: next-cycle implication failed");

`endif

// ----- rtl/bed_pkg.sv -----
// Types and constants shared by the backslash escape decoder modules.
package bed_pkg;

    // Parser phase of the front end.
    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_ESC  = 3'd1,
        PH_HEX1 = 3'd2,
        PH_HEX2 = 3'd3,
        PH_OCT  = 3'd4
    } phase_t;

    // One queued request: one or two result bytes. Only the first can be flagged.
    typedef struct packed {
        logic       two;
        logic [7:0] byte0;
        logic       bad0;
        logic [7:0] byte1;
    } cmd_t;

    // Input characters that the parser looks for.
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_C  = 8'h63;
    localparam logic [7:0] CH_LOW_E  = 8'h65;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_G  = 8'h67;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_V  = 8'h76;
    localparam logic [7:0] CH_LOW_X  = 8'h78;

    // Bytes produced by the named escapes.
    localparam logic [7:0] VAL_BS  = 8'h08;
    localparam logic [7:0] VAL_CSI = 8'h9B;
    localparam logic [7:0] VAL_ESC = 8'h1B;
    localparam logic [7:0] VAL_FF  = 8'h0C;
    localparam logic [7:0] VAL_BEL = 8'h07;
    localparam logic [7:0] VAL_LF  = 8'h0A;
    localparam logic [7:0] VAL_CR  = 8'h0D;
    localparam logic [7:0] VAL_TAB = 8'h09;
    localparam logic [7:0] VAL_VT  = 8'h0B;

endpackage

// ----- rtl/bed_fifo.sv -----
// Short request queue between the parser front end and the output back end.
`include "assert_macros.svh"

module bed_fifo #(
    parameter int DEPTH = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  bed_pkg::cmd_t push_data,
    output logic          full,
    input  logic          pop,
    output bed_pkg::cmd_t pop_data,
    output logic          empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    bed_pkg::cmd_t mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full     = (count_reg == FULL_CNT);
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    `ASSERT_IMPL(a_no_overflow, aclk, aresetn, push, !full)

endmodule

// ----- rtl/bed_front.sv -----
// Parser front end: accepts text bytes, tracks escapes and queues result requests.
`include "assert_macros.svh"

module bed_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [7:0]    s_axis_tdata,
    input  logic          s_axis_tuser,
    input  logic          full,
    output logic          push,
    output bed_pkg::cmd_t push_data
);

    bed_pkg::phase_t phase_reg, phase_next;
    logic [7:0] value_reg, value_next;
    logic       bad_reg, bad_next;
    logic [1:0] oct_reg, oct_next;

    logic       accept;
    logic       emit_any;
    logic [7:0] ch;
    logic [7:0] folded;
    logic       hex_ok;
    logic [3:0] hex_val;
    logic       oct_ok;
    logic [7:0] oct_sum;

    assign ch     = s_axis_tdata;
    assign folded = (ch >= 8'h41 && ch <= 8'h5A) ? ch + 8'h20 : ch;
    assign oct_ok = (ch[7:3] == 5'b00110);
    assign oct_sum = {value_reg[4:0], ch[2:0]};

    // Hex digit decode; anything else counts as zero.
    always_comb begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (ch >= 8'h30 && ch <= 8'h39) begin
            hex_val = ch[3:0];
        end else if ((ch >= 8'h61 && ch <= 8'h66) || (ch >= 8'h41 && ch <= 8'h46)) begin
            hex_val = ch[3:0] + 4'd9;
        end else begin
            hex_ok = 1'b0;
        end
    end

    assign s_axis_tready = !full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign push          = accept && emit_any;

    always_comb begin
        phase_next = phase_reg;
        value_next = value_reg;
        bad_next   = bad_reg;
        oct_next   = oct_reg;
        emit_any   = 1'b0;
        push_data  = '0;
        if (s_axis_tuser) begin
            // End of string: flush a pending number, drop an unfinished escape.
            if (phase_reg == bed_pkg::PH_HEX2 || phase_reg == bed_pkg::PH_OCT) begin
                emit_any        = 1'b1;
                push_data.byte0 = value_reg;
                push_data.bad0  = bad_reg;
            end
            phase_next = bed_pkg::PH_IDLE;
            value_next = 8'd0;
            bad_next   = 1'b0;
            oct_next   = 2'd0;
        end else begin
            case (phase_reg)
                bed_pkg::PH_ESC: begin
                    phase_next = bed_pkg::PH_IDLE;
                    emit_any   = 1'b1;
                    case (folded)
                        bed_pkg::CH_LF:    emit_any = 1'b0;
                        bed_pkg::CH_LOW_B: push_data.byte0 = bed_pkg::VAL_BS;
                        bed_pkg::CH_LOW_C: push_data.byte0 = bed_pkg::VAL_CSI;
                        bed_pkg::CH_LOW_E: push_data.byte0 = bed_pkg::VAL_ESC;
                        bed_pkg::CH_LOW_F: push_data.byte0 = bed_pkg::VAL_FF;
                        bed_pkg::CH_LOW_G: push_data.byte0 = bed_pkg::VAL_BEL;
                        bed_pkg::CH_LOW_N: push_data.byte0 = bed_pkg::VAL_LF;
                        bed_pkg::CH_LOW_R: push_data.byte0 = bed_pkg::VAL_CR;
                        bed_pkg::CH_LOW_T: push_data.byte0 = bed_pkg::VAL_TAB;
                        bed_pkg::CH_LOW_V: push_data.byte0 = bed_pkg::VAL_VT;
                        bed_pkg::CH_LOW_X: begin
                            emit_any   = 1'b0;
                            phase_next = bed_pkg::PH_HEX1;
                        end
                        bed_pkg::CH_RPAREN, bed_pkg::CH_BSLASH: begin
                            push_data.two   = 1'b1;
                            push_data.byte0 = bed_pkg::CH_BSLASH;
                            push_data.byte1 = folded;
                        end
                        default: begin
                            if (oct_ok) begin
                                emit_any   = 1'b0;
                                value_next = {5'd0, ch[2:0]};
                                bad_next   = 1'b0;
                                oct_next   = 2'd1;
                                phase_next = bed_pkg::PH_OCT;
                            end else begin
                                push_data.byte0 = folded;
                            end
                        end
                    endcase
                end
                bed_pkg::PH_HEX1: begin
                    // Any byte is taken as the first digit.
                    bad_next   = !hex_ok;
                    value_next = {4'd0, hex_val};
                    phase_next = bed_pkg::PH_HEX2;
                end
                bed_pkg::PH_HEX2: begin
                    emit_any        = 1'b1;
                    push_data.bad0  = bad_reg;
                    bad_next        = 1'b0;
                    if (hex_ok) begin
                        push_data.byte0 = {value_reg[3:0], hex_val};
                        phase_next      = bed_pkg::PH_IDLE;
                    end else begin
                        // The byte ends the number and is then handled as plain text.
                        push_data.byte0 = value_reg;
                        if (ch == bed_pkg::CH_BSLASH) begin
                            phase_next = bed_pkg::PH_ESC;
                        end else begin
                            push_data.two   = 1'b1;
                            push_data.byte1 = ch;
                            phase_next      = bed_pkg::PH_IDLE;
                        end
                    end
                end
                bed_pkg::PH_OCT: begin
                    if (oct_ok) begin
                        value_next = oct_sum;
                        if (oct_reg == 2'd2) begin
                            // Third digit completes the escape at once.
                            emit_any        = 1'b1;
                            push_data.byte0 = oct_sum;
                            phase_next      = bed_pkg::PH_IDLE;
                            oct_next        = 2'd0;
                        end else begin
                            oct_next = oct_reg + 2'd1;
                        end
                    end else begin
                        emit_any        = 1'b1;
                        push_data.byte0 = value_reg;
                        oct_next        = 2'd0;
                        if (ch == bed_pkg::CH_BSLASH) begin
                            phase_next = bed_pkg::PH_ESC;
                        end else begin
                            push_data.two   = 1'b1;
                            push_data.byte1 = ch;
                            phase_next      = bed_pkg::PH_IDLE;
                        end
                    end
                end
                default: begin
                    if (ch == bed_pkg::CH_BSLASH) begin
                        phase_next = bed_pkg::PH_ESC;
                    end else begin
                        emit_any        = 1'b1;
                        push_data.byte0 = ch;
                        phase_next      = bed_pkg::PH_IDLE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= bed_pkg::PH_IDLE;
            value_reg <= 8'd0;
            bad_reg   <= 1'b0;
            oct_reg   <= 2'd0;
        end else if (accept) begin
            phase_reg <= phase_next;
            value_reg <= value_next;
            bad_reg   <= bad_next;
            oct_reg   <= oct_next;
        end
    end

    `ASSERT_IMPL(a_oct_count, aclk, aresetn, phase_reg == bed_pkg::PH_OCT, oct_reg == 2'd1 || oct_reg == 2'd2)
    `ASSERT_IMPL(a_bad_only_hex2, aclk, aresetn, bad_reg, phase_reg == bed_pkg::PH_HEX2)

endmodule

// ----- rtl/bed_back.sv -----
// Output back end: drains queued requests into the registered result channel.
`include "assert_macros.svh"

module bed_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          empty,
    input  bed_pkg::cmd_t pop_data,
    output logic          pop,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [7:0]    m_axis_tdata,
    output logic          m_axis_tuser,
    output logic          m_axis_tlast
);

    logic       valid_reg, valid_next;
    logic [7:0] data_reg, data_next;
    logic       user_reg, user_next;
    logic       last_reg, last_next;
    logic       second_reg, second_next;
    logic [7:0] byte1_reg, byte1_next;
    logic       out_free;

    assign out_free = !valid_reg || m_axis_tready;
    assign pop      = out_free && !second_reg && !empty;

    always_comb begin
        valid_next  = valid_reg;
        data_next   = data_reg;
        user_next   = user_reg;
        last_next   = last_reg;
        second_next = second_reg;
        byte1_next  = byte1_reg;
        if (out_free) begin
            if (second_reg) begin
                // Second byte of a two-byte request is never flagged.
                valid_next  = 1'b1;
                data_next   = byte1_reg;
                user_next   = 1'b0;
                last_next   = 1'b1;
                second_next = 1'b0;
            end else if (!empty) begin
                valid_next  = 1'b1;
                data_next   = pop_data.byte0;
                user_next   = pop_data.bad0;
                last_next   = !pop_data.two;
                second_next = pop_data.two;
                byte1_next  = pop_data.byte1;
            end else begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end else begin
            valid_reg  <= valid_next;
            second_reg <= second_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg  <= data_next;
        user_reg  <= user_next;
        last_reg  <= last_next;
        byte1_reg <= byte1_next;
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;
    assign m_axis_tuser  = user_reg;
    assign m_axis_tlast  = last_reg;

    `ASSERT_IMPL(a_first_then_second, aclk, aresetn, valid_reg && !last_reg, second_reg)

endmodule

// ----- rtl/backslash_escape_decoder_top.sv -----
// Top level of the backslash escape decoder: parser front end, request queue, output back end.
//
// The s_axis channel takes one text byte per request: s_axis_tdata carries the byte and
// s_axis_tuser marks an end-of-string request, which flushes a hex or octal number still
// being collected and drops an unfinished escape. The m_axis channel returns decoded
// bytes: m_axis_tdata holds the byte, m_axis_tuser flags a hex escape whose first digit
// was not a hex digit, and m_axis_tlast marks the final result of a request.
// A request yields zero, one or two results.
// Throughput is one request per cycle while the queue is not full; a request that yields
// two results occupies the output register for both of them in turn. The queue between
// parser and output absorbs short runs of such requests, while a long run of them fills it.
// A request that yields results is written into the queue at the edge that accepts it, and
// its first result is loaded into the output register, which drives m_axis_tvalid, once
// that register is free; the result transfers when m_axis_tready is high.
// When the receiver stalls, results wait in the output register and the queue; the input
// keeps being accepted until the queue of QUEUE_DEPTH requests fills, then s_axis_tready
// drops. Reset (aresetn low, synchronous) returns the parser to plain text, empties the
// queue and clears m_axis_tvalid.
module backslash_escape_decoder_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,  // [7:0] char_in
    input  logic       s_axis_tuser,  // [0] mode (1 = end of string)
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,  // [7:0] out_byte
    output logic       m_axis_tuser,  // [0] bad_digit
    output logic       m_axis_tlast
);

    logic          q_push;
    logic          q_full;
    logic          q_pop;
    logic          q_empty;
    bed_pkg::cmd_t q_wr_data;
    bed_pkg::cmd_t q_rd_data;

    // Parser: classifies each byte and produces at most one queued request.
    bed_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .full          (q_full),
        .push          (q_push),
        .push_data     (q_wr_data)
    );

    // Queue lets the parser run on while the output is stalled.
    bed_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_wr_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_rd_data),
        .empty     (q_empty)
    );

    // Output stage: splits two-byte requests and holds results under backpressure.
    bed_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .empty         (q_empty),
        .pop_data      (q_rd_data),
        .pop           (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
